/* rtl/ltt_pkg.sv */
package ltt_pkg;

    localparam int COORD_BITS       = 24;
    localparam int ANGLE_ITERATIONS = 16;
    localparam int FRAC_BITS        = 16;
    localparam int TABLE_LEN        = 24;
    localparam int ROOT_STEPS       = COORD_BITS;
    localparam int DIV_STEPS        = 32;
    localparam int CNT_BITS         = 5;
    localparam int VEC_BITS         = COORD_BITS + FRAC_BITS + 4;
    localparam int ANG_BITS         = 32;
    // 180 degrees in hundredths, the scale the angle table is built on
    localparam int HALF_TURN_CDEG   = 180 * 100;

    localparam logic [2:0] CFG_RING_COUNT      = 3'd0;
    localparam logic [2:0] CFG_COLUMNS         = 3'd1;
    localparam logic [2:0] CFG_BOTTOM_ANGLE    = 3'd2;
    localparam logic [2:0] CFG_RING_RESOLUTION = 3'd3;
    localparam logic [2:0] CFG_SWEEP_TIME      = 3'd4;

    // atan(2^-i) in 2^-16 hundredths of a degree
    localparam logic [29:0] ATAN_TAB [TABLE_LEN] = '{
        30'd294912000, 30'd174096719, 30'd91987925, 30'd46694507,
        30'd23437865, 30'd11730358, 30'd5866610, 30'd2933484,
        30'd1466764, 30'd733385, 30'd366693, 30'd183346,
        30'd91673, 30'd45837, 30'd22918, 30'd11459,
        30'd5730, 30'd2865, 30'd1432, 30'd716,
        30'd358, 30'd179, 30'd90, 30'd45
    };

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
        logic signed [COORD_BITS-1:0] z_coord;
        logic                         end_of_cloud;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic signed [COORD_BITS-1:0] out_z;
        logic                         kept;
        logic [6:0]                   ring;
        logic [19:0]                  time_offset;
        logic                         last_point;
    } t_out_item;

    typedef struct packed {
        logic [7:0]         ring_count;
        logic [11:0]        columns_per_scan;
        logic signed [14:0] bottom_angle;
        logic [13:0]        ring_resolution;
        logic [19:0]        sweep_time;
    } t_cfg;

    typedef struct packed {
        t_in_item    item;
        logic [11:0] col;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_ROOT, S_ROT, S_SUM,
        S_RDIV, S_RCHK, S_TMUL, S_TDIV, S_DONE
    } t_state;

endpackage

/* rtl/ltt_front.sv */
module ltt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  ltt_pkg::t_in_item i_in_item,
    input  ltt_pkg::t_cfg    i_cfg,
    input  logic             i_q_full,
    output logic             o_q_push,
    output ltt_pkg::t_job    o_job
);
    import ltt_pkg::*;

    logic [11:0] r_count, n_count, col;
    logic [12:0] col_inc;

    // counter past the column count restarts at column 0
    assign col     = (r_count < i_cfg.columns_per_scan) ? r_count : 12'd0;
    assign col_inc = {1'b0, col} + 13'd1;
    assign o_q_push = push && !i_q_full;
    assign o_job    = '{item: i_in_item, col: col};

    always_comb begin
        n_count = r_count;
        if (o_q_push) begin
            if (i_cfg.columns_per_scan == 12'd0 ||
                col_inc >= {1'b0, i_cfg.columns_per_scan} ||
                i_in_item.end_of_cloud) begin
                n_count = 12'd0;
            end else begin
                n_count = col_inc[11:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 12'd0;
        end else begin
            r_count <= n_count;
        end
    end
endmodule

/* rtl/ltt_queue.sv */
module ltt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ltt_pkg::t_job i_job,
    input  logic          i_pop,
    output ltt_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);
    import ltt_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_fill;
    logic       do_push, do_pop;

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end
endmodule

/* rtl/ltt_back.sv */
module ltt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ltt_pkg::t_cfg      i_cfg,
    input  ltt_pkg::t_job      i_job,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  logic               pop,
    output logic               empty,
    output ltt_pkg::t_out_item o_out_item
);
    import ltt_pkg::*;

    t_state r_state, n_state;
    t_job   r_job;

    logic [CNT_BITS-1:0]        r_cnt;
    logic [2*COORD_BITS-1:0]    r_sq;
    logic [COORD_BITS+1:0]      r_rem;
    logic [COORD_BITS-1:0]      r_root;
    logic signed [VEC_BITS-1:0] r_a, r_b;
    logic signed [ANG_BITS-1:0] r_ang;
    logic                       r_zero, r_sneg, r_kept;
    logic [31:0]                r_dq;
    logic [13:0]                r_drem;
    logic [6:0]                 r_ring;
    logic                       r_ov;
    t_out_item                  r_out;

    // datapath wires
    logic signed [2*COORD_BITS-1:0] sq_prod;
    logic [COORD_BITS+3:0]          rt_sh, rt_trial;
    logic                           rt_ge;
    logic signed [VEC_BITS-1:0]     da, db;
    logic signed [ANG_BITS-1:0]     atan_v;
    logic signed [32:0]             s_sum;
    logic [32:0]                    s_abs;
    logic [13:0]                    dvs;
    logic [14:0]                    dv_sh;
    logic                           dv_ge;
    logic [7:0]                     rings;
    logic                           last_step;

    assign sq_prod = (r_state == S_SQX) ? r_job.item.x_coord * r_job.item.x_coord
                                        : r_job.item.y_coord * r_job.item.y_coord;

    assign rt_sh    = {r_rem, r_sq[2*COORD_BITS-1 -: 2]};
    assign rt_trial = {2'b00, r_root, 2'b01};
    assign rt_ge    = rt_sh >= rt_trial;

    assign da     = r_b >>> r_cnt;
    assign db     = r_a >>> r_cnt;
    assign atan_v = $signed({2'b00, ATAN_TAB[r_cnt]});

    assign s_sum = 33'(r_zero ? 32'sd0 : r_ang)
                 + ($signed(33'(i_cfg.bottom_angle)) <<< FRAC_BITS);
    assign s_abs = s_sum[32] ? 33'(-s_sum) : 33'(s_sum);

    assign dvs   = (r_state == S_RDIV) ? i_cfg.ring_resolution
                                       : {2'b00, i_cfg.columns_per_scan};
    assign dv_sh = {r_drem, r_dq[31]};
    assign dv_ge = dv_sh >= {1'b0, dvs};

    assign rings = (i_cfg.ring_count > 8'd128) ? 8'd128 : i_cfg.ring_count;

    always_comb begin
        unique case (r_state) inside
            S_ROOT:          last_step = (r_cnt == CNT_BITS'(ROOT_STEPS - 1));
            S_ROT:           last_step = (r_cnt == CNT_BITS'(ANGLE_ITERATIONS - 1));
            S_RDIV, S_TDIV:  last_step = (r_cnt == CNT_BITS'(DIV_STEPS - 1));
            default:         last_step = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_q_empty) n_state = S_SQX;
            S_SQX:  n_state = S_SQY;
            S_SQY:  n_state = S_ROOT;
            S_ROOT: if (last_step) n_state = S_ROT;
            S_ROT:  if (last_step) n_state = S_SUM;
            S_SUM:  n_state = S_RDIV;
            S_RDIV: if (last_step) n_state = S_RCHK;
            S_RCHK: n_state = S_TMUL;
            S_TMUL: n_state = (r_kept && i_cfg.columns_per_scan != 12'd0) ? S_TDIV : S_DONE;
            S_TDIV: if (last_step) n_state = S_DONE;
            S_DONE: if (!r_ov) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_pop = (r_state == S_IDLE) && !i_q_empty;
    end

    assign empty      = !r_ov;
    assign o_out_item = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && !r_ov) begin
                r_ov <= 1'b1;
            end else if (pop && r_ov) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= last_step ? '0 : r_cnt + CNT_BITS'(1);
        case (r_state) inside
            S_IDLE: begin
                r_job <= i_job;
                r_cnt <= '0;
            end
            S_SQX: r_sq <= unsigned'(sq_prod);
            S_SQY: begin
                r_sq   <= r_sq + unsigned'(sq_prod);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            S_ROOT: begin
                r_sq <= r_sq << 2;
                if (rt_ge) begin
                    r_rem  <= (COORD_BITS+2)'(rt_sh - rt_trial);
                    r_root <= {r_root[COORD_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= rt_sh[COORD_BITS+1:0];
                    r_root <= {r_root[COORD_BITS-2:0], 1'b0};
                end
                if (last_step) begin
                    r_a    <= $signed({4'b0000, rt_ge ? {r_root[COORD_BITS-2:0], 1'b1}
                                                      : {r_root[COORD_BITS-2:0], 1'b0},
                                       {FRAC_BITS{1'b0}}});
                    r_b    <= $signed(VEC_BITS'(r_job.item.z_coord)) <<< FRAC_BITS;
                    r_ang  <= '0;
                    r_zero <= (r_root[COORD_BITS-2:0] == '0) && !rt_ge
                              && (r_job.item.z_coord == '0);
                end
            end
            S_ROT: begin
                if (!r_b[VEC_BITS-1]) begin
                    r_a   <= r_a + da;
                    r_b   <= r_b - db;
                    r_ang <= r_ang + atan_v;
                end else begin
                    r_a   <= r_a - da;
                    r_b   <= r_b + db;
                    r_ang <= r_ang - atan_v;
                end
            end
            S_SUM: begin
                r_sneg <= s_sum[32];
                r_dq   <= 32'(s_abs >> FRAC_BITS);
                r_drem <= '0;
                r_cnt  <= '0;
            end
            S_RDIV, S_TDIV: begin
                r_dq   <= {r_dq[30:0], dv_ge};
                r_drem <= dv_ge ? 14'(dv_sh - {1'b0, dvs}) : dv_sh[13:0];
            end
            S_RCHK: begin
                r_kept <= (i_cfg.ring_resolution != 14'd0) &&
                          (!r_sneg || r_dq == 32'd0) && (r_dq < 32'(rings));
                r_ring <= r_dq[6:0];
            end
            S_TMUL: begin
                r_dq   <= 32'(r_job.col) * 32'(i_cfg.sweep_time);
                r_drem <= '0;
                r_cnt  <= '0;
            end
            S_DONE: begin
                if (!r_ov) begin
                    r_out.out_x       <= r_job.item.x_coord;
                    r_out.out_y       <= r_job.item.y_coord;
                    r_out.out_z       <= r_job.item.z_coord;
                    r_out.kept        <= r_kept;
                    r_out.ring        <= r_kept ? r_ring : 7'd0;
                    r_out.time_offset <= (r_kept && i_cfg.columns_per_scan != 12'd0)
                                         ? r_dq[19:0] : 20'd0;
                    r_out.last_point  <= r_job.item.end_of_cloud;
                end
            end
            default: ;
        endcase
    end
endmodule

/* rtl/lidar_ring_and_time_tagger.sv */
// Channel   | Handshake           | Payload
// ----------+---------------------+------------------------------------
// input     | push / full         | i_in_item (x, y, z, end_of_cloud)
// result    | empty / pop         | o_out_item (coords, kept, ring, time)
// config    | i_cfg_valid / ready | i_cfg_index, i_cfg_data
//
// In the back end a point passes a dequeue, squaring of x and y on a shared 24x24
// multiplier, 24 root steps, 16 CORDIC rotations, sum, check and multiply steps,
// two 32-step restoring divides (ring, then time; the time divide is skipped for
// dropped points and when the column count is zero) and an output load. A
// two-entry queue sits between front and back, and the output register holds one
// finished transaction; while it waits unpopped the back end holds in its last
// state, and input flows until the queue fills.
// Reset is synchronous; config is ready every cycle.
module lidar_ring_and_time_tagger (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  ltt_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output ltt_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data
);
    import ltt_pkg::*;

    t_cfg   r_cfg;
    t_job   fr_job, q_job;
    logic   q_push, q_pop, q_full, q_empty;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;

    // config register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ring_count       <= 8'd32;
            r_cfg.columns_per_scan <= 12'd1875;
            r_cfg.bottom_angle     <= 15'sd700;
            r_cfg.ring_resolution  <= 14'd100;
            r_cfg.sweep_time       <= 20'd100000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RING_COUNT:      r_cfg.ring_count       <= i_cfg_data[7:0];
                CFG_COLUMNS:         r_cfg.columns_per_scan <= i_cfg_data[11:0];
                CFG_BOTTOM_ANGLE:    r_cfg.bottom_angle     <= $signed(i_cfg_data[14:0]);
                CFG_RING_RESOLUTION: r_cfg.ring_resolution  <= i_cfg_data[13:0];
                CFG_SWEEP_TIME:      r_cfg.sweep_time       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: column tagging and enqueue
    ltt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .i_in_item (i_in_item),
        .i_cfg     (r_cfg),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_job     (fr_job)
    );

    ltt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (fr_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: range, elevation, ring and time
    ltt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_job      (q_job),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .pop        (pop),
        .empty      (empty),
        .o_out_item (o_out_item)
    );
endmodule

/* test/tb_lidar_ring_and_time_tagger.sv */
`timescale 1ns / 100ps

module tb_lidar_ring_and_time_tagger;
    import ltt_pkg::*;

    // allow margin for the back end to finish its last point
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 2000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    t_in_item           i_in_item;
    logic               empty;
    logic               pop;
    t_out_item          o_out_item;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [19:0]        i_cfg_data;

    lidar_ring_and_time_tagger u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor copy of the configuration registers and the column counter.
    logic [7:0]         pr_rings;
    logic [11:0]        pr_columns;
    logic signed [14:0] pr_bottom;
    logic [13:0]        pr_res;
    logic [19:0]        pr_period;
    logic [11:0]        pr_col;

    t_out_item tagged_points[$];
    int        mismatches = 0;
    int        cycles = 0;
    bit        quiet_mode;   // suppress random idling on both sides

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("lidar_ring_and_time_tagger test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] res, bitv, rem;
        res = '0;
        rem = n;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC: elevation in 2^-16 hundredths of a degree.
    function automatic longint elev_angle(input longint r, input longint z);
        longint a, b, ang, da, db;
        longint steps [24] = '{294912000, 174096719, 91987925, 46694507,
            23437865, 11730358, 5866610, 2933484, 1466764, 733385, 366693,
            183346, 91673, 45837, 22918, 11459, 5730, 2865, 1432, 716, 358,
            179, 90, 45};
        a = r <<< FRAC_BITS;
        b = z <<< FRAC_BITS;
        ang = 0;
        if (r == 0 && z == 0) return 0;
        for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0) begin
                a += da; b -= db; ang += steps[i];
            end else begin
                a -= da; b += db; ang -= steps[i];
            end
        end
        return ang;
    endfunction

    // Tag one point and advance the column counter.
    function automatic t_out_item tag_point(input t_in_item p);
        t_out_item  o;
        longint     x, y, z, r, ang, s, d, q, nrings;
        logic [63:0] ux, uy, prod;
        logic [11:0] col;
        x = p.x_coord; y = p.y_coord; z = p.z_coord;
        ux = (x < 0) ? -x : x;
        uy = (y < 0) ? -y : y;
        r = root_floor(ux * ux + uy * uy);
        ang = elev_angle(r, z);
        nrings = (pr_rings > 128) ? 128 : pr_rings;
        o = '0;
        o.out_x = p.x_coord; o.out_y = p.y_coord; o.out_z = p.z_coord;
        o.last_point = p.end_of_cloud;
        if (pr_res != 0) begin
            s = ang + (longint'(pr_bottom) <<< FRAC_BITS);
            d = longint'(pr_res) <<< FRAC_BITS;
            q = s / d;
            if (q >= 0 && q < nrings) begin
                o.kept = 1'b1;
                o.ring = q[6:0];
            end
        end
        col = (pr_col < pr_columns) ? pr_col : 12'd0;
        if (o.kept && pr_columns != 0) begin
            prod = 64'(col) * 64'(pr_period);
            o.time_offset = 20'(prod / 64'(pr_columns));
        end
        if (pr_columns == 0 || 13'(col) + 13'd1 >= 13'(pr_columns)) pr_col = 0;
        else pr_col = col + 12'd1;
        if (p.end_of_cloud) pr_col = 0;
        return o;
    endfunction

    // Result side: random stalls, compare each popped transaction.
    always @(negedge i_clk) begin
        if (!i_rst_n) pop <= 1'b0;
        else pop <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 19);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (tagged_points.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_out_item), 64'd0);
            end else begin
                want = tagged_points.pop_front();
                if (o_out_item.out_x !== want.out_x)
                    report_mismatch("out_x", 64'(o_out_item.out_x), 64'(want.out_x));
                if (o_out_item.out_y !== want.out_y)
                    report_mismatch("out_y", 64'(o_out_item.out_y), 64'(want.out_y));
                if (o_out_item.out_z !== want.out_z)
                    report_mismatch("out_z", 64'(o_out_item.out_z), 64'(want.out_z));
                if (o_out_item.kept !== want.kept)
                    report_mismatch("kept", 64'(o_out_item.kept), 64'(want.kept));
                if (o_out_item.ring !== want.ring)
                    report_mismatch("ring", 64'(o_out_item.ring), 64'(want.ring));
                if (o_out_item.time_offset !== want.time_offset)
                    report_mismatch("time_offset", 64'(o_out_item.time_offset),
                                    64'(want.time_offset));
                if (o_out_item.last_point !== want.last_point)
                    report_mismatch("last_point", 64'(o_out_item.last_point),
                                    64'(want.last_point));
            end
        end
    end

    // Send one point; random idle before it, hold until accepted.
    // push stays high after acceptance; idling or a drain drops it.
    task automatic send_point(input t_in_item p);
        while (!quiet_mode && $urandom_range(99) < 19) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_in_item <= p;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        tagged_points.insert(tagged_points.size(), tag_point(p));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (tagged_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Register write; only called with the block idle.
    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_RING_COUNT:      pr_rings   = val[7:0];
            CFG_COLUMNS:         pr_columns = val[11:0];
            CFG_BOTTOM_ANGLE:    pr_bottom  = val[14:0];
            CFG_RING_RESOLUTION: pr_res     = val[13:0];
            CFG_SWEEP_TIME:      pr_period  = val[19:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_config(input int rings, input int cols, input int bottom,
                              input int res, input int period);
        wait_drained();
        write_reg(CFG_RING_COUNT, 20'(rings));
        write_reg(CFG_COLUMNS, 20'(cols));
        write_reg(CFG_BOTTOM_ANGLE, 20'(bottom));
        write_reg(CFG_RING_RESOLUTION, 20'(res));
        write_reg(CFG_SWEEP_TIME, 20'(period));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item make_point(input int x, input int y, input int z,
                                            input bit eoc);
        t_in_item p;
        p.x_coord = x[23:0]; p.y_coord = y[23:0]; p.z_coord = z[23:0];
        p.end_of_cloud = eoc;
        return p;
    endfunction

    // Coordinates mostly in a realistic range, sometimes full-scale.
    function automatic int rand_coord();
        case ($urandom_range(3))
            0: return int'($urandom) >>> 8;
            1: return $urandom_range(0, 200) - 100;
            default: return $urandom_range(0, 200000) - 100000;
        endcase
    endfunction

    task automatic test_directed();
        send_point(make_point(0, 0, 0, 0));                    // origin
        send_point(make_point(8388607, 8388607, 8388607, 0));
        send_point(make_point(-8388608, -8388608, -8388608, 0));
        send_point(make_point(0, 0, 8388607, 0));              // straight up
        send_point(make_point(0, 0, -8388608, 0));             // straight down
        send_point(make_point(10000, 0, -1222, 0));            // near bottom ring
        send_point(make_point(10000, 0, 3000, 0));
        send_point(make_point(-5000, 5000, 100, 1));           // end of cloud
        send_point(make_point(5000, -5000, -100, 0));
        send_point(make_point(1, 0, 0, 0));
        send_point(make_point(0, -1, 0, 1));
    endtask

    task automatic test_config_extremes();
        set_config(128, 1, -9000, 1, 1000000);
        repeat (6) send_point(make_point(rand_coord(), rand_coord(), rand_coord(), 0));
        set_config(1, 4095, 9000, 9000, 1);
        repeat (6) send_point(make_point(rand_coord(), rand_coord(), rand_coord(), 0));
        // zero resolution, zero rings, zero columns, ring count above 128
        set_config(0, 0, 0, 0, 0);
        repeat (3) send_point(make_point(rand_coord(), rand_coord(), rand_coord(), 0));
        set_config(255, 3, 9000, 50, 1000000);
        repeat (8) send_point(make_point(rand_coord(), rand_coord(), rand_coord(), 0));
    endtask

    task automatic test_random_clouds(input int count);
        int n;
        n = 0;
        while (n < count) begin
            send_point(make_point(rand_coord(), rand_coord(), rand_coord(),
                                  $urandom_range(99) < 3));
            n++;
            // pause until everything has drained once in a while
            if (n % 300 == 150) begin
                push <= 1'b0;
                while (tagged_points.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_in_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_RING_COUNT;
        i_cfg_data = '0;
        quiet_mode = 1'b0;
        pr_rings = 8'd32; pr_columns = 12'd1875; pr_bottom = 15'sd700;
        pr_res = 14'd100; pr_period = 20'd100000; pr_col = 12'd0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_config_extremes();
        set_config(32, 1875, 700, 100, 100000);
        test_random_clouds(400);
        set_config($urandom_range(1, 128), $urandom_range(1, 20), 1500,
                   $urandom_range(1, 300), $urandom_range(1, 1000000));
        quiet_mode = 1'b1;        // long stretch with no idling on either side
        test_random_clouds(300);
        quiet_mode = 1'b0;
        set_config(64, 7, -300, 25, 999999);
        test_random_clouds(450);

        wait_drained();
        if (mismatches == 0) begin
            $display("lidar_ring_and_time_tagger test passed");
        end else begin
            $display("lidar_ring_and_time_tagger test failed");
        end
        $finish;
    end

endmodule
